@@ sv/rpkc_pkg.sv @@
// Shared types, codes and character helpers for the relative path key checker.
package rpkc_pkg;

   localparam int CNT_W = 12;
   localparam logic [CNT_W-1:0] CNT_MAX = 12'hFFF;
   // longest reserved device name
   localparam int DEV_BYTES = 7;

   localparam logic [1:0] ACT_BYTE  = 2'd0;
   localparam logic [1:0] ACT_LAST  = 2'd1;
   localparam logic [1:0] ACT_EMPTY = 2'd2;

   localparam logic [1:0] CSR_MAX_KEY_LENGTH  = 2'd0;
   localparam logic [1:0] CSR_MAX_PART_LENGTH = 2'd1;
   localparam logic [1:0] CSR_BACKSLASH_SEP   = 2'd2;

   localparam logic [CNT_W-1:0] MAX_KEY_RESET  = 12'd1024;
   localparam logic [CNT_W-1:0] MAX_PART_RESET = 12'd255;

   typedef enum logic [3:0] {
      REASON_OK          = 4'd0,
      REASON_EMPTY       = 4'd1,
      REASON_NUL         = 4'd2,
      REASON_LONG_KEY    = 4'd3,
      REASON_LEAD_SEP    = 4'd4,
      REASON_DRIVE       = 4'd5,
      REASON_EMPTY_PART  = 4'd6,
      REASON_DOT_PART    = 4'd7,
      REASON_COLON       = 4'd8,
      REASON_LONG_PART   = 4'd9,
      REASON_EDGE_DOT    = 4'd10,
      REASON_TRAIL_SPACE = 4'd11,
      REASON_RESERVED    = 4'd12
   } reason_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [7:0]       last_byte;
      logic             colon;
   } part_state_type;

   function automatic logic [7:0] fold(input logic [7:0] b);
      if (b >= "A" && b <= "Z") begin
         return b + 8'd32;
      end
      return b;
   endfunction

   function automatic logic is_letter(input logic [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
   endfunction

endpackage

@@ sv/relative_path_key_checker_core.sv @@
// Top level of the relative path key checker: input stage, per-key state, result register.
// A key's last byte is registered in the input stage; its result then goes to the result register.
// Throughput: one byte per cycle unless the result stalls; each byte goes through one
// registered update of the per-key counters, flags and the component verdict logic.
// Back-pressure: input stalls only while its staged byte waits on a stalled result.
// Reset (synchronous): clears all counters, flags and valids; limits return to 1024 / 255.
module relative_path_key_checker_core #(
   parameter int NAME_WINDOW_BYTES = 7
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_action,
   input  logic [7:0]                   req_key_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_valid_res,
   output logic [3:0]                   rsp_reason,
   input  logic                         csr_write_enable,
   input  logic [1:0]                   csr_index,
   input  logic [rpkc_pkg::CNT_W-1:0]   csr_write_data
);
   import rpkc_pkg::*;

   localparam int WIN_IDX_W = $clog2(NAME_WINDOW_BYTES);

   logic [CNT_W-1:0] max_key_ff, max_part_ff;
   logic             bsl_ff;

   logic             in_valid_ff, in_valid_in;
   logic [1:0]       in_action_ff;
   logic [7:0]       in_byte_ff;

   logic [CNT_W-1:0] key_count_ff, key_count_in;
   part_state_type   part_ff, part_in;
   logic [NAME_WINDOW_BYTES-1:0][7:0] window_ff, window_in;
   logic [7:0]       key_first_ff, key_first_in;
   logic             nul_ff, nul_in;
   logic             drive_ff, drive_in;
   reason_type       fault_ff, fault_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_res_ff, rsp_res_in;
   reason_type       rsp_reason_ff, rsp_reason_in;

   logic             advance, step, sep;
   logic [CNT_W-1:0] key_count_n;
   part_state_type   part_n, check_part;
   logic [NAME_WINDOW_BYTES-1:0][7:0] window_n;
   logic [DEV_BYTES-1:0][7:0] check_win;
   logic [7:0]       key_first_n;
   logic             nul_n, drive_n;
   reason_type       verdict, fault_after, part_final, why;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   // byte-level update of key and component state
   always_comb begin
      sep = (in_byte_ff == "/") || (bsl_ff && in_byte_ff == "\\");
      key_first_n = (key_count_ff == '0) ? in_byte_ff : key_first_ff;
      drive_n = drive_ff ||
                (key_count_ff == 12'd1 && in_byte_ff == ":" && is_letter(key_first_ff));
      nul_n = nul_ff || (in_byte_ff == 8'd0);
      key_count_n = (key_count_ff != CNT_MAX) ? key_count_ff + 12'd1 : key_count_ff;

      window_n = window_ff;
      part_n   = part_ff;
      if (!sep) begin
         if (part_ff.count < CNT_W'(NAME_WINDOW_BYTES)) begin
            window_n[part_ff.count[WIN_IDX_W-1:0]] = in_byte_ff;
         end
         part_n.colon     = part_ff.colon || (in_byte_ff == ":");
         part_n.last_byte = in_byte_ff;
         if (part_ff.count != CNT_MAX) begin
            part_n.count = part_ff.count + 12'd1;
         end
      end

      // a separator closes the component before it; a last byte closes the updated one
      check_part = sep ? part_ff : part_n;
      check_win  = sep ? window_ff[DEV_BYTES-1:0] : window_n[DEV_BYTES-1:0];
   end

   rpkc_part_check u_part_check (
      .part                 (check_part),
      .win                  (check_win),
      .max_component_length (max_part_ff),
      .verdict              (verdict)
   );

   always_comb begin
      fault_after = (fault_ff == REASON_OK) ? verdict : fault_ff;
      // separator as last byte leaves an empty trailing component
      if (sep && fault_after == REASON_OK) begin
         part_final = REASON_EMPTY_PART;
      end else begin
         part_final = fault_after;
      end

      priority if (nul_n) begin
         why = REASON_NUL;
      end else if (key_count_n > max_key_ff) begin
         why = REASON_LONG_KEY;
      end else if (key_first_n == "/" || key_first_n == "\\") begin
         why = REASON_LEAD_SEP;
      end else if (drive_n) begin
         why = REASON_DRIVE;
      end else begin
         why = part_final;
      end
   end

   always_comb begin
      key_count_in  = key_count_ff;
      part_in       = part_ff;
      window_in     = window_ff;
      key_first_in  = key_first_ff;
      nul_in        = nul_ff;
      drive_in      = drive_ff;
      fault_in      = fault_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_res_in    = rsp_res_ff;
      rsp_reason_in = rsp_reason_ff;

      if (step) begin
         unique case (in_action_ff)
            ACT_BYTE: begin
               key_count_in = key_count_n;
               window_in    = window_n;
               key_first_in = key_first_n;
               nul_in       = nul_n;
               drive_in     = drive_n;
               if (sep) begin
                  part_in  = '0;
                  fault_in = fault_after;
               end else begin
                  part_in  = part_n;
               end
            end
            ACT_LAST: begin
               key_count_in  = '0;
               part_in       = '0;
               key_first_in  = '0;
               nul_in        = 1'b0;
               drive_in      = 1'b0;
               fault_in      = REASON_OK;
               rsp_valid_in  = 1'b1;
               rsp_res_in    = (why == REASON_OK);
               rsp_reason_in = why;
            end
            ACT_EMPTY: begin
               key_count_in  = '0;
               part_in       = '0;
               key_first_in  = '0;
               nul_in        = 1'b0;
               drive_in      = 1'b0;
               fault_in      = REASON_OK;
               rsp_valid_in  = 1'b1;
               rsp_res_in    = 1'b0;
               rsp_reason_in = REASON_EMPTY;
            end
            default: begin
               // unused action: drop the beat
            end
         endcase
      end
   end

   always_comb begin
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else begin
         in_valid_in = in_valid_ff && !advance;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_key_ff   <= MAX_KEY_RESET;
         max_part_ff  <= MAX_PART_RESET;
         bsl_ff       <= 1'b0;
         in_valid_ff  <= 1'b0;
         key_count_ff <= '0;
         part_ff      <= '0;
         key_first_ff <= '0;
         nul_ff       <= 1'b0;
         drive_ff     <= 1'b0;
         fault_ff     <= REASON_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_MAX_KEY_LENGTH:  max_key_ff  <= csr_write_data;
               CSR_MAX_PART_LENGTH: max_part_ff <= csr_write_data;
               CSR_BACKSLASH_SEP:   bsl_ff      <= csr_write_data[0];
               default: begin
               end
            endcase
         end
         in_valid_ff  <= in_valid_in;
         key_count_ff <= key_count_in;
         part_ff      <= part_in;
         key_first_ff <= key_first_in;
         nul_ff       <= nul_in;
         drive_ff     <= drive_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_action_ff <= req_action;
         in_byte_ff   <= req_key_byte;
      end
      window_ff     <= window_in;
      rsp_res_ff    <= rsp_res_in;
      rsp_reason_ff <= rsp_reason_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_res_ff;
   assign rsp_reason    = rsp_reason_ff;

   a_res_matches_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_res_ff == (rsp_reason_ff == REASON_OK)))
      else $error("accept flag disagrees with reason code");

   a_key_cleared_after_result: assert property (@(posedge clock) disable iff (reset)
      step && (in_action_ff == ACT_LAST || in_action_ff == ACT_EMPTY) |=>
         (key_count_ff == '0 && part_ff.count == '0 && fault_ff == REASON_OK))
      else $error("per-key state not cleared after a result");

   a_stall_only_when_staged: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff))
      else $error("input stalled with nothing staged");

   a_part_within_key: assert property (@(posedge clock) disable iff (reset)
      part_ff.count <= key_count_ff)
      else $error("component length exceeds key length");

endmodule

@@ sv/rpkc_part_check.sv @@
// Verdict for one closed path component: empty, dot names, colon, length, edge dots, trailing space, device names.
module rpkc_part_check (
   input  rpkc_pkg::part_state_type                       part,
   input  logic [rpkc_pkg::DEV_BYTES-1:0][7:0]            win,
   input  logic [rpkc_pkg::CNT_W-1:0]                     max_component_length,
   output rpkc_pkg::reason_type                           verdict
);
   import rpkc_pkg::*;

   logic [DEV_BYTES-1:0][7:0] f;
   logic                      dev;
   logic                      prefix4;

   always_comb begin
      for (int i = 0; i < DEV_BYTES; i++) begin
         f[i] = fold(win[i]);
      end
      prefix4 = ({f[0], f[1], f[2]} == "com") || ({f[0], f[1], f[2]} == "lpt");
      unique case (part.count)
         12'd3: dev = ({f[0], f[1], f[2]} == "con") || ({f[0], f[1], f[2]} == "prn") ||
                      ({f[0], f[1], f[2]} == "aux") || ({f[0], f[1], f[2]} == "nul");
         // digit is compared unfolded
         12'd4: dev = prefix4 && win[3] >= "1" && win[3] <= "9";
         12'd6: dev = ({f[0], f[1], f[2], f[3], f[4], f[5]} == "clock$") ||
                      ({f[0], f[1], f[2], f[3], f[4], f[5]} == "conin$");
         12'd7: dev = {f[0], f[1], f[2], f[3], f[4], f[5], f[6]} == "conout$";
         default: dev = 1'b0;
      endcase
   end

   always_comb begin
      priority if (part.count == '0) begin
         verdict = REASON_EMPTY_PART;
      end else if ((part.count == 12'd1 && win[0] == ".") ||
                   (part.count == 12'd2 && win[0] == "." && win[1] == ".")) begin
         verdict = REASON_DOT_PART;
      end else if (part.colon) begin
         verdict = REASON_COLON;
      end else if (part.count > max_component_length) begin
         verdict = REASON_LONG_PART;
      end else if (win[0] == "." || part.last_byte == ".") begin
         verdict = REASON_EDGE_DOT;
      end else if (part.last_byte == " ") begin
         verdict = REASON_TRAIL_SPACE;
      end else if (dev) begin
         verdict = REASON_RESERVED;
      end else begin
         verdict = REASON_OK;
      end
   end

endmodule
